>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, idle while reset is asserted.
`define BPCM_ASSERT(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("bpcm port check failed");

// Concurrent check that also holds during reset.
`define BPCM_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) \
        else $error("bpcm reset check failed");

`endif

>>> rtl/bpcm_pkg.sv
// Types, constants and helper functions of the banded covariance multiply.
`timescale 1ns / 1ps

package bpcm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CORR_W     = 18;
    localparam int RESULT_W   = 40;
    localparam int POS_W      = 20;
    localparam int CNT_W      = 21;
    localparam int ROW_W      = 11;
    localparam int LEN_W      = 21;
    localparam int BAND_W     = 3;
    localparam int MAX_ROW    = 1024;
    localparam int MAX_LENGTH = 1048576;
    localparam int NUM_CLASS  = 6;
    localparam int SPAN       = 5;
    localparam int NUM_TAPS   = SPAN * SPAN;
    localparam int NUM_LINES  = SPAN - 1;
    localparam int PROD_W     = SAMPLE_W + CORR_W;
    localparam int GROUP_W    = PROD_W + 3;
    localparam int ADDR_W     = $clog2(NUM_LINES * MAX_ROW + 1);
    localparam int JQ_DEPTH   = 4;
    localparam int JQ_PTR_W   = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_W   = JQ_PTR_W + 1;
    localparam int OF_DEPTH   = 8;
    localparam int OF_PTR_W   = $clog2(OF_DEPTH);
    localparam int OF_CNT_W   = OF_PTR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORR_CENTER       = 3'd0,
        REG_CORR_ADJACENT     = 3'd1,
        REG_CORR_DIAGONAL     = 3'd2,
        REG_CORR_TWO_AWAY     = 3'd3,
        REG_CORR_KNIGHT       = 3'd4,
        REG_CORR_FAR_DIAGONAL = 3'd5,
        REG_ROW_WIDTH         = 3'd6,
        REG_VECTOR_LENGTH     = 3'd7
    } cfg_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [CORR_W-1:0]   corr_t;
    typedef sample_t [SPAN-1:0]         group_t;

    typedef struct packed {
        logic    mode;
        sample_t sample;
    } sample_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic [POS_W-1:0]           position;
        logic                       last;
    } result_item_t;

    typedef struct packed {
        corr_t [NUM_CLASS-1:0] corr;
        logic [ROW_W-1:0]      row_width;
        logic [LEN_W-1:0]      vector_length;
    } cfg_t;

    typedef struct packed {
        sample_t [NUM_TAPS-1:0] taps;
        logic [POS_W-1:0]       position;
        logic                   last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } jq_wr_t;

    typedef struct packed {
        logic [JQ_CNT_W-1:0] count;
        logic                empty;
    } jq_stat_t;

    function automatic logic [BAND_W-1:0] tap_class(input int j, input int i);
        int a;
        int b;
        int lo;
        int hi;
        logic [BAND_W-1:0] c;
        a  = (j < 2) ? 2 - j : j - 2;
        b  = (i < 2) ? 2 - i : i - 2;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (hi == 0)
            c = 3'd0;
        else if (hi == 1)
            c = (lo == 0) ? 3'd1 : 3'd2;
        else
            c = (lo == 0) ? 3'd3 : ((lo == 1) ? 3'd4 : 3'd5);
        return c;
    endfunction

    function automatic logic [BAND_W-1:0] pick_level(input corr_t [NUM_CLASS-1:0] corr);
        logic signed [CORR_W+5:0] x50;
        logic                     found;
        logic [BAND_W-1:0]        lvl;
        found = 1'b0;
        lvl   = BAND_W'(NUM_CLASS - 1);
        for (int k = 1; k < NUM_CLASS; k++)
        begin
            x50 = ((CORR_W+6)'(corr[k]) <<< 5) + ((CORR_W+6)'(corr[k]) <<< 4)
                + ((CORR_W+6)'(corr[k]) <<< 1);
            if (!found && (x50 < (CORR_W+6)'(corr[0])))
            begin
                found = 1'b1;
                lvl   = BAND_W'(k - 1);
            end
        end
        return lvl;
    endfunction

endpackage

>>> rtl/banded_pixel_covariance_multiply_top.sv
// Top level of the banded 5x5 covariance multiply over a streamed pixel vector.
// One item per cycle when not full; line buffer RAMs take one write and one read each.
// Result path: front register, job queue, job, product and sum registers, result queue.
// A vector takes vector_length sample items and 2*row_width+2 flush items.
// Reset clears counters, queue pointers and valid bits; line RAMs are not cleared.
`timescale 1ns / 1ps

module banded_pixel_covariance_multiply_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  bpcm_pkg::sample_item_t        sample_item,
    output logic                          empty,
    input  logic                          pop,
    output bpcm_pkg::result_item_t        result_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpcm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpcm_pkg::*;

    corr_t [NUM_CLASS-1:0] corr_reg;
    logic [ROW_W-1:0]      row_width_reg;
    logic [LEN_W-1:0]      vector_length_reg;
    cfg_t                  cfg;
    jq_wr_t                jq_wr;
    jq_stat_t              jq_stat;
    job_t                  jq_head;
    logic                  jq_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg          <= '0;
            row_width_reg     <= ROW_W'(1);
            vector_length_reg <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CORR_CENTER:       corr_reg[0] <= corr_t'(cfg_data[CORR_W-1:0]);
                REG_CORR_ADJACENT:     corr_reg[1] <= corr_t'(cfg_data[CORR_W-1:0]);
                REG_CORR_DIAGONAL:     corr_reg[2] <= corr_t'(cfg_data[CORR_W-1:0]);
                REG_CORR_TWO_AWAY:     corr_reg[3] <= corr_t'(cfg_data[CORR_W-1:0]);
                REG_CORR_KNIGHT:       corr_reg[4] <= corr_t'(cfg_data[CORR_W-1:0]);
                REG_CORR_FAR_DIAGONAL: corr_reg[5] <= corr_t'(cfg_data[CORR_W-1:0]);
                REG_ROW_WIDTH:         row_width_reg <= cfg_data[ROW_W-1:0];
                REG_VECTOR_LENGTH:     vector_length_reg <= cfg_data[LEN_W-1:0];
                default:               corr_reg <= corr_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.corr = corr_reg;
        if (row_width_reg == '0)
            cfg.row_width = ROW_W'(1);
        else if (row_width_reg > ROW_W'(MAX_ROW))
            cfg.row_width = ROW_W'(MAX_ROW);
        else
            cfg.row_width = row_width_reg;
        if (vector_length_reg == '0)
            cfg.vector_length = LEN_W'(1);
        else if (vector_length_reg > LEN_W'(MAX_LENGTH))
            cfg.vector_length = LEN_W'(MAX_LENGTH);
        else
            cfg.vector_length = vector_length_reg;
    end

    bpcm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .sample_item (sample_item),
        .cfg         (cfg),
        .jq_stat     (jq_stat),
        .full        (full),
        .jq_wr       (jq_wr)
    );

    bpcm_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .jq_wr   (jq_wr),
        .jq_pop  (jq_pop),
        .jq_head (jq_head),
        .jq_stat (jq_stat)
    );

    bpcm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .jq_head     (jq_head),
        .jq_stat     (jq_stat),
        .cfg         (cfg),
        .jq_pop      (jq_pop),
        .pop         (pop),
        .empty       (empty),
        .result_item (result_item)
    );

endmodule

>>> rtl/bpcm_front.sv
// Front end: item intake, position tracking, line buffers and tap gathering.
`timescale 1ns / 1ps

module bpcm_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bpcm_pkg::sample_item_t sample_item,
    input  bpcm_pkg::cfg_t         cfg,
    input  bpcm_pkg::jq_stat_t     jq_stat,
    output logic                   full,
    output bpcm_pkg::jq_wr_t       jq_wr
);
    import bpcm_pkg::*;

    logic [CNT_W-1:0]    taken_reg, taken_next;
    logic [BAND_W-1:0]   band_reg, band_next, band_now;
    sample_t [SPAN-2:0]  hist_reg;
    logic                accept;
    sample_t             cur;
    group_t              grp;
    logic [ROW_W:0]      lag;
    logic [CNT_W-1:0]    pos_full;
    logic                emit;
    logic                last;
    logic [JQ_CNT_W:0]   load;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr [NUM_LINES];

    logic                f1_valid_reg;
    logic                f1_emit_reg;
    logic                f1_last_reg;
    logic [CNT_W-1:0]    f1_t_reg;
    logic [BAND_W-1:0]   f1_band_reg;
    logic [POS_W-1:0]    f1_pos_reg;
    group_t              f1_row0_reg;
    group_t              line_rd_reg [NUM_LINES];

    sample_t [NUM_TAPS-1:0] taps;

    assign load   = (JQ_CNT_W+1)'(jq_stat.count)
                  + (JQ_CNT_W+1)'(f1_valid_reg & f1_emit_reg);
    assign full   = (load >= (JQ_CNT_W+1)'(JQ_DEPTH));
    assign accept = push & ~full;

    assign lag      = {cfg.row_width, 1'b0} + (ROW_W+1)'(2);
    assign band_now = (taken_reg == '0) ? pick_level(cfg.corr) : band_reg;
    assign cur      = (!sample_item.mode && (taken_reg < cfg.vector_length))
                    ? sample_item.sample : '0;
    assign pos_full = taken_reg - CNT_W'(lag);
    assign wr_addr  = taken_reg[ADDR_W-1:0];

    always_comb
    begin
        grp[0] = cur;
        for (int i = 1; i < SPAN; i++)
        begin
            grp[i] = hist_reg[i-1];
        end
        for (int g = 0; g < NUM_LINES; g++)
        begin
            rd_addr[g] = wr_addr - ADDR_W'((g + 1) * cfg.row_width);
        end
    end

    always_comb
    begin
        taken_next = taken_reg;
        band_next  = band_reg;
        emit       = 1'b0;
        last       = 1'b0;
        if (accept)
        begin
            band_next = band_now;
            if (taken_reg < CNT_W'(lag))
            begin
                taken_next = taken_reg + CNT_W'(1);
            end
            else if (pos_full >= cfg.vector_length)
            begin
                taken_next = '0;
            end
            else
            begin
                emit       = 1'b1;
                last       = (pos_full == cfg.vector_length - LEN_W'(1));
                taken_next = last ? '0 : taken_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg    <= '0;
            band_reg     <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            taken_reg    <= taken_next;
            band_reg     <= band_next;
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg    <= grp[SPAN-2:0];
            f1_emit_reg <= emit;
            f1_last_reg <= last;
            f1_t_reg    <= taken_reg;
            f1_band_reg <= band_now;
            f1_pos_reg  <= pos_full[POS_W-1:0];
            f1_row0_reg <= grp;
        end
    end

    for (genvar g = 0; g < NUM_LINES; g++)
    begin : g_line
        group_t line_mem [2**ADDR_W];

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                line_mem[wr_addr] <= grp;
                line_rd_reg[g]    <= line_mem[rd_addr[g]];
            end
        end
    end

    always_comb
    begin
        logic [CNT_W-1:0] off;
        logic [CNT_W-1:0] q;
        logic             keep;
        sample_t          src;
        for (int j = 0; j < SPAN; j++)
        begin
            for (int i = 0; i < SPAN; i++)
            begin
                src  = (j == 0) ? f1_row0_reg[i] : line_rd_reg[(j == 0) ? 0 : j - 1][i];
                off  = CNT_W'(j * cfg.row_width + i);
                q    = f1_t_reg - off;
                keep = (f1_t_reg >= off) && (q < cfg.vector_length)
                    && (tap_class(j, i) <= f1_band_reg);
                taps[j*SPAN+i] = keep ? src : '0;
            end
        end
    end

    assign jq_wr.valid        = f1_valid_reg & f1_emit_reg;
    assign jq_wr.job.taps     = taps;
    assign jq_wr.job.position = f1_pos_reg;
    assign jq_wr.job.last     = f1_last_reg;

endmodule

>>> rtl/bpcm_jobq.sv
// Job queue between the front end and the multiply back end.
`timescale 1ns / 1ps

module bpcm_jobq (
    input  logic               clk,
    input  logic               rst_n,
    input  bpcm_pkg::jq_wr_t   jq_wr,
    input  logic               jq_pop,
    output bpcm_pkg::job_t     jq_head,
    output bpcm_pkg::jq_stat_t jq_stat
);
    import bpcm_pkg::*;

    job_t                jq_mem [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JQ_CNT_W-1:0] count_reg, count_next;
    logic                do_pop;

    assign do_pop = jq_pop & (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (jq_wr.valid)
        begin
            wr_ptr_next = wr_ptr_reg + JQ_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + JQ_PTR_W'(1);
        end
        case ({jq_wr.valid, do_pop})
            2'b10:   count_next = count_reg + JQ_CNT_W'(1);
            2'b01:   count_next = count_reg - JQ_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (jq_wr.valid)
        begin
            jq_mem[wr_ptr_reg] <= jq_wr.job;
        end
    end

    assign jq_head       = jq_mem[rd_ptr_reg];
    assign jq_stat.count = count_reg;
    assign jq_stat.empty = (count_reg == '0);

endmodule

>>> rtl/bpcm_back.sv
// Back end: 25 tap multiplies, registered adder tree and result queue.
`timescale 1ns / 1ps

module bpcm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bpcm_pkg::job_t         jq_head,
    input  bpcm_pkg::jq_stat_t     jq_stat,
    input  bpcm_pkg::cfg_t         cfg,
    output logic                   jq_pop,
    input  logic                   pop,
    output logic                   empty,
    output bpcm_pkg::result_item_t result_item
);
    import bpcm_pkg::*;

    logic                      v1_reg, v2_reg, v3_reg;
    job_t                      job_reg;
    logic signed [PROD_W-1:0]  prod_reg [NUM_TAPS];
    logic signed [PROD_W-1:0]  prod_next [NUM_TAPS];
    logic [POS_W-1:0]          pos2_reg, pos3_reg;
    logic                      last2_reg, last3_reg;
    logic signed [GROUP_W-1:0] part_reg [SPAN];
    logic signed [GROUP_W-1:0] part_next [SPAN];
    logic signed [RESULT_W-1:0] total;

    result_item_t              of_mem [OF_DEPTH];
    logic [OF_PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [OF_CNT_W-1:0]       of_count_reg, of_count_next;
    logic [OF_CNT_W:0]         busy;
    logic                      out_take;

    assign busy   = (OF_CNT_W+1)'(of_count_reg) + (OF_CNT_W+1)'(v1_reg)
                  + (OF_CNT_W+1)'(v2_reg) + (OF_CNT_W+1)'(v3_reg);
    assign jq_pop = !jq_stat.empty && (busy < (OF_CNT_W+1)'(OF_DEPTH));

    always_comb
    begin
        for (int j = 0; j < SPAN; j++)
        begin
            for (int i = 0; i < SPAN; i++)
            begin
                prod_next[j*SPAN+i] = PROD_W'(cfg.corr[tap_class(j, i)])
                                    * PROD_W'(job_reg.taps[j*SPAN+i]);
            end
        end
        for (int g = 0; g < SPAN; g++)
        begin
            part_next[g] = '0;
            for (int i = 0; i < SPAN; i++)
            begin
                part_next[g] = part_next[g] + GROUP_W'(prod_reg[g*SPAN+i]);
            end
        end
        total = '0;
        for (int g = 0; g < SPAN; g++)
        begin
            total = total + RESULT_W'(part_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= jq_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (jq_pop)
        begin
            job_reg <= jq_head;
        end
        prod_reg  <= prod_next;
        pos2_reg  <= job_reg.position;
        last2_reg <= job_reg.last;
        part_reg  <= part_next;
        pos3_reg  <= pos2_reg;
        last3_reg <= last2_reg;
    end

    assign out_take = pop & ~empty;

    always_comb
    begin
        case ({v3_reg, out_take})
            2'b10:   of_count_next = of_count_reg + OF_CNT_W'(1);
            2'b01:   of_count_next = of_count_reg - OF_CNT_W'(1);
            default: of_count_next = of_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            of_count_reg <= '0;
        end
        else
        begin
            if (v3_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + OF_PTR_W'(1);
            end
            if (out_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + OF_PTR_W'(1);
            end
            of_count_reg <= of_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            of_mem[wr_ptr_reg].result   <= total;
            of_mem[wr_ptr_reg].position <= pos3_reg;
            of_mem[wr_ptr_reg].last     <= last3_reg;
        end
    end

    assign empty       = (of_count_reg == '0);
    assign result_item = of_mem[rd_ptr_reg];

endmodule

>>> rtl/bpcm_checker.sv
// Port-level checks of the covariance multiply, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpcm_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic pop,
    input logic empty
);

    `BPCM_ASSERT_ALWAYS(a_empty_in_reset, clk, !rst_n |-> empty)
    `BPCM_ASSERT(a_full_needs_transfer, clk, rst_n, (!full && !push) |=> !full)
    `BPCM_ASSERT(a_result_holds, clk, rst_n, (!empty && !pop) |=> !empty)

endmodule

bind banded_pixel_covariance_multiply_top bpcm_checker u_bpcm_checker (.*);

>>> sim/banded_pixel_covariance_multiply_top_tb.sv
// Testbench for the banded 5x5 covariance multiply: directed and random vectors checked by a predictor.
`timescale 1ns / 1ps

module banded_pixel_covariance_multiply_top_tb;

    import bpcm_pkg::*;

    localparam int WIN_SIZE  = 4 * MAX_ROW + 5;
    localparam int SETTLE    = 20;
    localparam int RAND_GOAL = 950;

    logic           clk;
    logic           rst_n;
    logic           push;
    logic           full;
    sample_item_t   sample_item;
    logic           empty;
    logic           pop;
    result_item_t   result_item;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block state
    corr_t              corr_val [NUM_CLASS];
    logic [ROW_W-1:0]   row_reg;
    logic [LEN_W-1:0]   len_reg;
    sample_t            window [WIN_SIZE];
    int unsigned        taken;
    int unsigned        band;

    result_item_t       sums_due [$];
    int                 errors;
    int                 items_sent;
    bit                 gaps_on;
    int                 hold_left;
    int                 pop_stall;

    banded_pixel_covariance_multiply_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #24_000_000;
        $display("banded_pixel_covariance_multiply_top_tb: done, errors");
        $finish;
    end

    function automatic int unsigned row_eff();
        if (row_reg == 0)
            return 1;
        return (row_reg > MAX_ROW) ? MAX_ROW : row_reg;
    endfunction

    function automatic int unsigned len_eff();
        if (len_reg == 0)
            return 1;
        return (len_reg > MAX_LENGTH) ? MAX_LENGTH : len_reg;
    endfunction

    function automatic int unsigned band_from_corr();
        for (int k = 1; k < NUM_CLASS; k++)
            if (longint'(50) * corr_val[k] < longint'(corr_val[0]))
                return k - 1;
        return NUM_CLASS - 1;
    endfunction

    function automatic int unsigned offset_class(int dy, int dx);
        int a;
        int b;
        int lo;
        int hi;
        a  = (dy < 0) ? -dy : dy;
        b  = (dx < 0) ? -dx : dx;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (hi == 0)
            return 0;
        if (hi == 1)
            return (lo == 0) ? 1 : 2;
        return (lo == 0) ? 3 : ((lo == 1) ? 4 : 5);
    endfunction

    task automatic stencil_step(input logic mode, input sample_t s);
        int unsigned rw;
        int unsigned len;
        int unsigned lag;
        longint      p;
        longint      q;
        longint      acc;
        int unsigned c;
        result_item_t r;
        rw  = row_eff();
        len = len_eff();
        lag = 2 * rw + 2;
        acc = 0;
        if (taken == 0)
            band = band_from_corr();
        window[taken % WIN_SIZE] = (mode == 1'b0 && taken < len) ? s : sample_t'(0);
        if (taken < lag)
        begin
            taken++;
            return;
        end
        p = longint'(taken) - lag;
        if (p >= len)
        begin
            taken = 0;
            return;
        end
        for (int dy = -2; dy <= 2; dy++)
            for (int dx = -2; dx <= 2; dx++)
            begin
                c = offset_class(dy, dx);
                q = p + dy * longint'(rw) + dx;
                if (c <= band && q >= 0 && q < len)
                    acc += longint'(corr_val[c]) * longint'(window[q % WIN_SIZE]);
            end
        r.result   = acc[RESULT_W-1:0];
        r.position = p[POS_W-1:0];
        r.last     = (p == len - 1);
        sums_due   = {sums_due, r};
        taken = (p >= len - 1) ? 0 : taken + 1;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (sums_due.size() == 0)
                report("unexpected transfer, position", result_item.position, -1);
            else
            begin
                if (result_item.result !== sums_due[0].result)
                    report("result", result_item.result, sums_due[0].result);
                if (result_item.position !== sums_due[0].position)
                    report("position", result_item.position, sums_due[0].position);
                if (result_item.last !== sums_due[0].last)
                    report("last", result_item.last, sums_due[0].last);
                void'(sums_due.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (pop_stall > 0)
        begin
            pop_stall--;
            pop <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 99) < 20)
        begin
            pop_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_ROW_WIDTH)
            row_reg = data[ROW_W-1:0];
        else if (idx == REG_VECTOR_LENGTH)
            len_reg = data[LEN_W-1:0];
        else
            corr_val[idx] = data[CORR_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_corr(input int k, input corr_t c);
        write_reg(cfg_reg_t'(REG_CORR_CENTER + k), {3'($urandom), c});
    endtask

    task automatic wait_drained();
        while (sums_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic send_item(input logic mode, input sample_t s);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 25)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        <= 1'b1;
        sample_item <= '{mode: mode, sample: s};
        @(posedge clk);
        while (full)
            @(posedge clk);
        stencil_step(mode, s);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return sample_t'(-32768);
            1: return sample_t'(32767);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // one full vector: samples then flushes; noisy vectors mix the modes at random
    task automatic send_vector(input bit noisy);
        int unsigned n;
        int unsigned len;
        len = len_eff();
        n   = len + 2 * row_eff() + 2;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy)
                send_item(1'($urandom), pick_sample());
            else
                send_item(i < len ? 1'b0 : 1'b1, pick_sample());
        end
        push <= 1'b0;
    endtask

    task automatic set_shape(input int unsigned rw, input int unsigned len);
        write_reg(REG_ROW_WIDTH, {10'($urandom), ROW_W'(rw)});
        write_reg(REG_VECTOR_LENGTH, LEN_W'(len));
    endtask

    // corr values tuned so the band level comes out as lvl
    task automatic set_band(input int lvl);
        int c0;
        int thr;
        c0  = $urandom_range(5000, 131071);
        thr = c0 / 50;
        write_corr(0, corr_t'(c0));
        for (int k = 1; k < NUM_CLASS; k++)
        begin
            if (k <= lvl)
                write_corr(k, corr_t'($urandom_range(thr + 1, 131071)));
            else if (k == lvl + 1)
                write_corr(k, corr_t'(int'($urandom_range(0, thr - 1 + 131072)) - 131072));
            else
                write_corr(k, corr_t'($urandom));
        end
    endtask

    task automatic test_reset_state();
        send_vector(1'b0);
        wait_drained();
    endtask

    task automatic test_extremes();
        for (int k = 0; k < NUM_CLASS; k++)
            write_corr(k, corr_t'(131071));
        set_shape(3, 9);
        send_vector(1'b0);
        wait_drained();
        for (int k = 0; k < NUM_CLASS; k++)
            write_corr(k, corr_t'(-131072));
        send_vector(1'b0);
        wait_drained();
    endtask

    task automatic test_shape_limits();
        set_band(5);
        set_shape(0, 3);
        send_vector(1'b0);
        wait_drained();
        write_reg(REG_VECTOR_LENGTH, '0);
        send_vector(1'b0);
        wait_drained();
        write_reg(REG_ROW_WIDTH, {CFG_DATA_W{1'b1}});
        write_reg(REG_VECTOR_LENGTH, {CFG_DATA_W{1'b1}});
        set_shape(4, 6);
        send_vector(1'b0);
        wait_drained();
    endtask

    task automatic test_mode_mixups();
        set_shape(2, 7);
        send_vector(1'b1);
        wait_drained();
    endtask

    task automatic test_band_levels();
        for (int lvl = 0; lvl < NUM_CLASS; lvl++)
        begin
            set_band(lvl);
            set_shape($urandom_range(1, 4), $urandom_range(4, 14));
            send_vector(1'b0);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        set_band(5);
        set_shape(1, 60);
        gaps_on   = 1'b0;
        hold_left = 300;
        send_vector(1'b0);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random();
        while (items_sent < RAND_GOAL)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    for (int k = 0; k < NUM_CLASS; k++)
                        write_corr(k, corr_t'($urandom));
                else
                    set_band($urandom_range(0, NUM_CLASS - 1));
                set_shape(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8),
                          $urandom_range(1, 40));
            end
            gaps_on = ($urandom_range(0, 4) != 0);
            send_vector($urandom_range(0, 9) == 0);
            wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        sample_item  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_CORR_CENTER;
        cfg_data     = '0;
        errors       = 0;
        items_sent   = 0;
        gaps_on      = 1'b1;
        hold_left    = 0;
        pop_stall    = 0;
        taken        = 0;
        band         = 0;
        row_reg      = 1;
        len_reg      = 1;
        for (int k = 0; k < NUM_CLASS; k++)
            corr_val[k] = '0;
        for (int i = 0; i < WIN_SIZE; i++)
            window[i] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_extremes();
        test_shape_limits();
        test_mode_mixups();
        test_band_levels();
        test_backpressure();
        test_random();

        wait_drained();
        if (sums_due.size() != 0)
            report("results left over", sums_due.size(), 0);
        if (errors == 0)
            $display("banded_pixel_covariance_multiply_top_tb: done, clean");
        else
            $display("banded_pixel_covariance_multiply_top_tb: done, errors");
        $finish;
    end

endmodule
